// File: hdl/tkci_pkg.sv
// Shared constants and codes for the time-keyed calibration interpolator.
// No dependencies; the interfaces and the top level use this package.
package tkci_pkg;

	localparam int FIELD_BITS = 32;
	localparam int STAMP_BITS = 32;
	localparam int MAX_LAYERS = 7;
	localparam int LAYER_IDX_BITS = 3;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BEFORE    = 2'd1,
		ST_AFTER     = 2'd2,
		ST_REJECTED  = 2'd3
	} status_t;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef enum logic {
		MODE_NEAREST = 1'b0,
		MODE_LINEAR  = 1'b1
	} mode_t;

endpackage

// File: hdl/tkci_if.sv
// Channel interfaces of the interpolator: input items, result items and
// the configuration write channel. Depends on tkci_pkg for field widths.
interface tkci_in_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   kind;
	logic [tkci_pkg::STAMP_BITS-1:0]        stamp;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_in_0;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_in_1;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_in_2;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_in_3;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_in_4;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_in_5;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_in_6;
	modport source (output valid, kind, stamp, offset_in_0, offset_in_1, offset_in_2,
		offset_in_3, offset_in_4, offset_in_5, offset_in_6, input ready);
	modport sink (input valid, kind, stamp, offset_in_0, offset_in_1, offset_in_2,
		offset_in_3, offset_in_4, offset_in_5, offset_in_6, output ready);
endinterface

interface tkci_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             status;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_out_0;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_out_1;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_out_2;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_out_3;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_out_4;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_out_5;
	logic signed [tkci_pkg::FIELD_BITS-1:0] offset_out_6;
	modport source (output valid, status, offset_out_0, offset_out_1, offset_out_2,
		offset_out_3, offset_out_4, offset_out_5, offset_out_6, input ready);
	modport sink (input valid, status, offset_out_0, offset_out_1, offset_out_2,
		offset_out_3, offset_out_4, offset_out_5, offset_out_6, output ready);
endinterface

interface tkci_cfg_if;
	logic valid;
	logic ready;
	logic interp_mode;
	modport source (output valid, interp_mode, input ready);
	modport sink (input valid, interp_mode, output ready);
endinterface

// File: hdl/time_keyed_calibration_interpolator_top.sv
// A load goes from acceptance straight to the output step. A query runs binary-search
// steps (at most clog2(TABLE_DEPTH)+1 steps), each a read and a compare state, fetches both
// bracketing entries, then picks the nearer entry in nearest mode or divides per layer in
// linear mode, where one shared shift-subtract divider makes one quotient bit per cycle.
// One item is in work at a time; a finished result waits in the output register.
// Reset (arst_n low) empties the table and sets linear mode; no clearing pass is needed.
module time_keyed_calibration_interpolator_top #(
	parameter int TABLE_DEPTH = 1024,
	parameter int LAYERS = 7,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	tkci_in_if.sink     in_ch,
	tkci_out_if.source  out_ch,
	tkci_cfg_if.sink    cfg
);

	localparam int FB = tkci_pkg::FIELD_BITS;
	localparam int SB = tkci_pkg::STAMP_BITS;
	localparam int ML = tkci_pkg::MAX_LAYERS;
	localparam int LB = tkci_pkg::LAYER_IDX_BITS;
	localparam int VB = VALUE_BITS;
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = LAYERS * VB;
	localparam int QW = VB + 1;
	localparam int SW = $clog2(QW + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_FETCH0, S_FETCH1, S_FETCH2,
		S_LAYER, S_DIV, S_FIN, S_PUSH
	} state_t;

	state_t state_q;

	logic [SB-1:0] stamp_mem [TABLE_DEPTH];
	logic [RW-1:0] row_mem [TABLE_DEPTH];
	logic [SB-1:0] stamp_rd_q;
	logic [RW-1:0] row_rd_q;
	logic [AW-1:0] rd_addr;

	logic          mode_q;
	logic [CW-1:0] cnt_q;
	logic [SB-1:0] last_stamp_q;
	logic [SB-1:0] t_q;
	logic [CW-1:0] lo_q, hi_q;
	logic [SB-1:0] s0_q;
	logic [RW-1:0] row0_q, row1_q;
	logic [SB-1:0] a_q, b_q, d_q;
	logic [LB-1:0] lay_q;
	logic [QW-1:0] ua_q, quo_q;
	logic [SB-1:0] rem_q;
	logic          neg_q;
	logic [SW-1:0] step_q;
	logic [1:0]    res_status_q;
	logic [FB-1:0] res_q [ML];

	logic [FB-1:0] in_off [ML];
	logic [RW-1:0] in_row;
	logic [CW-1:0] mid, lo_m1;
	logic          load_ok;
	logic          in_acc, out_acc;
	logic signed [VB-1:0] v0, v1;
	logic signed [QW-1:0] diff;
	logic [SB+1:0] trial, two_d;
	logic signed [VB+1:0] base, base_adj;
	logic [FB+VB-1:0] res_wide;

	assign in_off[0] = in_ch.offset_in_0;
	assign in_off[1] = in_ch.offset_in_1;
	assign in_off[2] = in_ch.offset_in_2;
	assign in_off[3] = in_ch.offset_in_3;
	assign in_off[4] = in_ch.offset_in_4;
	assign in_off[5] = in_ch.offset_in_5;
	assign in_off[6] = in_ch.offset_in_6;

	// Each loaded offset is the low VALUE_BITS of its field, sign-extended when wider.
	always_comb begin
		logic [FB+VB-1:0] ext;
		in_row = '0;
		for (int j = 0; j < LAYERS; j++) begin
			ext = {{VB{in_off[j][FB-1]}}, in_off[j]};
			in_row[j*VB +: VB] = ext[VB-1:0];
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_acc     = out_ch.valid && out_ch.ready;

	assign load_ok = (cnt_q < CW'(TABLE_DEPTH)) &&
		((cnt_q == '0) || (last_stamp_q < in_ch.stamp));

	assign mid   = lo_q + ((hi_q - lo_q) >> 1);
	assign lo_m1 = lo_q - CW'(1);

	always_comb begin
		unique case (state_q)
			S_FETCH0: rd_addr = lo_m1[AW-1:0];
			S_FETCH1: rd_addr = lo_q[AW-1:0];
			default:  rd_addr = mid[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_ch.kind == tkci_pkg::KIND_LOAD && load_ok) begin
			stamp_mem[cnt_q[AW-1:0]] <= in_ch.stamp;
			row_mem[cnt_q[AW-1:0]]   <= in_row;
		end
		stamp_rd_q <= stamp_mem[rd_addr];
		row_rd_q   <= row_mem[rd_addr];
	end

	assign v0   = row0_q[lay_q*VB +: VB];
	assign v1   = row1_q[lay_q*VB +: VB];
	assign diff = QW'(v1) - QW'(v0);

	// Quotient digit of (2*rem + bit*a) / d is at most two since rem < d and a < d.
	assign two_d = {1'b0, d_q, 1'b0};
	assign trial = {1'b0, rem_q, 1'b0} + (ua_q[QW-1] ? {2'b00, a_q} : '0);

	assign base = neg_q ? ((VB+2)'(v0) - (VB+2)'({1'b0, quo_q}))
		: ((VB+2)'(v0) + (VB+2)'({1'b0, quo_q}));

	always_comb begin
		base_adj = base;
		if (rem_q != '0) begin
			if (!base[VB+1] && base != '0 && neg_q)
				base_adj = base - (VB+2)'(1);
			else if (base[VB+1] && !neg_q)
				base_adj = base + (VB+2)'(1);
		end
		res_wide = {{FB{1'b0}}, base_adj[VB-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b1;
			cnt_q        <= '0;
			state_q      <= S_IDLE;
			out_ch.valid <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready)
				mode_q <= cfg.interp_mode;
			if (out_acc && state_q != S_PUSH)
				out_ch.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						t_q          <= in_ch.stamp;
						lo_q         <= '0;
						hi_q         <= cnt_q;
						lay_q        <= '0;
						for (int j = 0; j < ML; j++)
							res_q[j] <= '0;
						if (in_ch.kind == tkci_pkg::KIND_LOAD) begin
							if (load_ok) begin
								cnt_q        <= cnt_q + CW'(1);
								last_stamp_q <= in_ch.stamp;
								res_status_q <= tkci_pkg::ST_OK;
							end else begin
								res_status_q <= tkci_pkg::ST_REJECTED;
							end
							state_q <= S_PUSH;
						end else begin
							res_status_q <= tkci_pkg::ST_OK;
							state_q      <= S_SRCH_RD;
						end
					end
				end
				S_SRCH_RD: begin
					if (lo_q < hi_q) begin
						state_q <= S_SRCH_CMP;
					end else if (lo_q == '0) begin
						res_status_q <= tkci_pkg::ST_BEFORE;
						state_q      <= S_PUSH;
					end else if (lo_q >= cnt_q) begin
						res_status_q <= tkci_pkg::ST_AFTER;
						state_q      <= S_PUSH;
					end else begin
						state_q <= S_FETCH0;
					end
				end
				S_SRCH_CMP: begin
					if (stamp_rd_q > t_q)
						hi_q <= mid;
					else
						lo_q <= mid + CW'(1);
					state_q <= S_SRCH_RD;
				end
				S_FETCH0: state_q <= S_FETCH1;
				S_FETCH1: begin
					s0_q    <= stamp_rd_q;
					row0_q  <= row_rd_q;
					state_q <= S_FETCH2;
				end
				S_FETCH2: begin
					row1_q  <= row_rd_q;
					a_q     <= t_q - s0_q;
					b_q     <= stamp_rd_q - t_q;
					d_q     <= stamp_rd_q - s0_q;
					state_q <= S_LAYER;
				end
				S_LAYER: begin
					if (mode_q == tkci_pkg::MODE_NEAREST) begin
						for (int j = 0; j < LAYERS; j++) begin
							res_q[j] <= FB'({{FB{1'b0}},
								(a_q < b_q) ? row0_q[j*VB +: VB] : row1_q[j*VB +: VB]});
						end
						state_q <= S_PUSH;
					end else begin
						neg_q   <= diff[QW-1];
						ua_q    <= diff[QW-1] ? QW'(-diff) : QW'(diff);
						quo_q   <= '0;
						rem_q   <= '0;
						step_q  <= SW'(QW);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (trial >= two_d) begin
						rem_q <= SB'(trial - two_d);
						quo_q <= {quo_q[QW-2:0], 1'b0} + QW'(2);
					end else if (trial >= {2'b00, d_q}) begin
						rem_q <= SB'(trial - {2'b00, d_q});
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= trial[SB-1:0];
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
					ua_q   <= {ua_q[QW-2:0], 1'b0};
					step_q <= step_q - SW'(1);
					if (step_q == SW'(1))
						state_q <= S_FIN;
				end
				S_FIN: begin
					res_q[lay_q] <= res_wide[FB-1:0];
					lay_q        <= lay_q + LB'(1);
					if (lay_q == LB'(LAYERS - 1))
						state_q <= S_PUSH;
					else
						state_q <= S_LAYER;
				end
				S_PUSH: begin
					if (!out_ch.valid || out_ch.ready) begin
						out_ch.valid <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload is loaded together with valid in the output stage.
	always_ff @(posedge clk) begin
		if (state_q == S_PUSH && (!out_ch.valid || out_ch.ready)) begin
			out_ch.status       <= res_status_q;
			out_ch.offset_out_0 <= res_q[0];
			out_ch.offset_out_1 <= res_q[1];
			out_ch.offset_out_2 <= res_q[2];
			out_ch.offset_out_3 <= res_q[3];
			out_ch.offset_out_4 <= res_q[4];
			out_ch.offset_out_5 <= res_q[5];
			out_ch.offset_out_6 <= res_q[6];
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_load_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.kind == tkci_pkg::KIND_LOAD && load_ok)
		|=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("accepted load did not append an entry");

	a_result_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(state_q == S_PUSH))
		else $error("result raised outside the output step");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status != tkci_pkg::ST_OK) |->
		(out_ch.offset_out_0 == '0 && out_ch.offset_out_6 == '0))
		else $error("error result carries nonzero offsets");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH_CMP) |-> (lo_q < hi_q && hi_q <= cnt_q))
		else $error("search window out of range");
`endif

endmodule

// File: tb/tb_time_keyed_calibration_interpolator_top.sv
// Testbench for the time-keyed calibration interpolator: loads, queries and mode changes.
// Depends on tkci_pkg, the channel interfaces in hdl/tkci_if.sv and the top level RTL.
`timescale 1ns / 100ps

class calib_scoreboard;
	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] offs [7];
	} calib_result_t;

	logic [31:0]        stamps [$];
	logic signed [31:0] table_offs [$][7];
	bit                 linear_mode = 1'b1;
	calib_result_t      pending [$];
	int                 errors = 0;

	// Interpolation is exact: 32-bit values times 65-bit signed weights fit in 128 bits.
	function automatic logic signed [31:0] blend(logic signed [31:0] v0, logic signed [31:0] v1,
			longint unsigned a, longint unsigned d);
		logic signed [127:0] num;
		logic signed [127:0] q;
		num = $signed(128'(v0)) * $signed({1'b0, 64'(d - a)})
			+ $signed(128'(v1)) * $signed({1'b0, 64'(a)});
		q = num / $signed({1'b0, 64'(d)});
		return q[31:0];
	endfunction

	function void note_item(logic kind, logic [31:0] stamp, logic signed [31:0] offs [7]);
		calib_result_t r;
		int lo;
		int hi;
		int mid;
		longint unsigned a;
		longint unsigned b;
		r.status = tkci_pkg::ST_OK;
		foreach (r.offs[j]) r.offs[j] = '0;
		if (kind == tkci_pkg::KIND_LOAD) begin
			if (stamps.size() >= 1024 || (stamps.size() > 0 && stamps[$] >= stamp)) begin
				r.status = tkci_pkg::ST_REJECTED;
			end else begin
				stamps.insert(stamps.size(), stamp);
				table_offs.insert(table_offs.size(), offs);
			end
		end else begin
			lo = 0;
			hi = stamps.size();
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (stamps[mid] > stamp) hi = mid;
				else lo = mid + 1;
			end
			if (lo == 0) begin
				r.status = tkci_pkg::ST_BEFORE;
			end else if (lo >= stamps.size()) begin
				r.status = tkci_pkg::ST_AFTER;
			end else begin
				a = stamp - stamps[lo-1];
				b = stamps[lo] - stamp;
				foreach (r.offs[j]) begin
					if (linear_mode) r.offs[j] = blend(table_offs[lo-1][j], table_offs[lo][j], a, a + b);
					else r.offs[j] = (a < b) ? table_offs[lo-1][j] : table_offs[lo][j];
				end
			end
		end
		pending.insert(pending.size(), r);
	endfunction

	function void check_result(logic [1:0] status, logic signed [31:0] offs [7]);
		calib_result_t e;
		if (pending.size() == 0) begin
			$error("unexpected result item, status %0d", status);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (status !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, status);
			errors++;
		end
		foreach (offs[j]) if (offs[j] !== e.offs[j]) begin
			$error("offset_out_%0d: expected %0d, got %0d", j, e.offs[j], offs[j]);
			errors++;
		end
	endfunction
endclass

module tb_time_keyed_calibration_interpolator_top;

	logic clk;
	logic arst_n;
	tkci_in_if  in_ch ();
	tkci_out_if out_ch ();
	tkci_cfg_if cfg ();

	calib_scoreboard sb;
	bit   hold_off = 1'b0;
	bit   feed_done = 1'b0;
	longint cycles = 0;

	time_keyed_calibration_interpolator_top DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = 1'b0;
		in_ch.stamp = '0;
		in_ch.offset_in_0 = '0;
		in_ch.offset_in_1 = '0;
		in_ch.offset_in_2 = '0;
		in_ch.offset_in_3 = '0;
		in_ch.offset_in_4 = '0;
		in_ch.offset_in_5 = '0;
		in_ch.offset_in_6 = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.interp_mode = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Valid drops only for a gap, so a following item is offered without a bubble.
	task automatic send_item(logic kind, logic [31:0] stamp, logic signed [31:0] offs [7], int cap);
		int gap;
		gap = $urandom_range(0, cap);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.stamp <= stamp;
		in_ch.offset_in_0 <= offs[0];
		in_ch.offset_in_1 <= offs[1];
		in_ch.offset_in_2 <= offs[2];
		in_ch.offset_in_3 <= offs[3];
		in_ch.offset_in_4 <= offs[4];
		in_ch.offset_in_5 <= offs[5];
		in_ch.offset_in_6 <= offs[6];
		do @(posedge clk); while (!in_ch.ready);
		sb.note_item(kind, stamp, offs);
	endtask

	task automatic write_mode(logic mode);
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.interp_mode <= mode;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		sb.linear_mode = mode;
	endtask

	function automatic logic [31:0] rand_value(bit wide);
		case ($urandom_range(0, 4))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 200) - 100;
			default: return wide ? $urandom() : ($urandom_range(0, 2000) - 1000);
		endcase
	endfunction

	task automatic send_load(logic [31:0] stamp, int cap);
		logic signed [31:0] offs [7];
		foreach (offs[j]) offs[j] = rand_value(1'b1);
		send_item(tkci_pkg::KIND_LOAD, stamp, offs, cap);
	endtask

	task automatic send_query(logic [31:0] stamp, int cap);
		logic signed [31:0] offs [7];
		foreach (offs[j]) offs[j] = $urandom();
		send_item(tkci_pkg::KIND_QUERY, stamp, offs, cap);
	endtask

	// Receiver: random stalls, plus one long hold-off requested by the stimulus.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.status, '{out_ch.offset_out_0, out_ch.offset_out_1,
					out_ch.offset_out_2, out_ch.offset_out_3, out_ch.offset_out_4,
					out_ch.offset_out_5, out_ch.offset_out_6});
		end
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ch.ready <= 1'b0;
				repeat (2000) @(posedge clk);
				hold_off = 1'b0;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (stall == 0) begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int cap;
		logic signed [31:0] offs [7];
		wait (arst_n);
		@(posedge clk);
		// Directed: empty-table query, extremes, rejections, both modes, ties.
		send_query(32'd0, 0);
		send_query(32'hffffffff, 0);
		foreach (offs[j]) offs[j] = 32'sh80000000;
		send_item(tkci_pkg::KIND_LOAD, 32'd0, offs, 0);
		send_query(32'd0, 0);
		foreach (offs[j]) offs[j] = 32'sh7fffffff;
		send_item(tkci_pkg::KIND_LOAD, 32'd10, offs, 0);
		send_load(32'd10, 0);
		send_load(32'd5, 0);
		send_query(32'd5, 0);
		send_query(32'd3, 0);
		send_query(32'd10, 0);
		send_load(32'd13, 0);
		send_query(32'd11, 0);
		write_mode(tkci_pkg::MODE_NEAREST);
		send_query(32'd5, 0);
		send_query(32'd4, 0);
		send_query(32'd6, 0);
		send_query(32'd0, 0);
		send_query(32'd12, 0);
		send_load(32'hffffffff, 0);
		send_query(32'h80000000, 0);
		send_query(32'hfffffffe, 0);
		send_query(32'hffffffff, 0);
		send_load(32'hffffffff, 0);
		write_mode(tkci_pkg::MODE_LINEAR);
		send_query(32'h7fffffff, 0);
		// Random phases: the largest stamp closes the table, so random loads are
		// rejected and the queries probe the four stored entries in both modes.
		for (int ph = 0; ph < 6; ph++) begin
			cap = (ph % 2) ? 10 : 0;
			if (ph == 2) hold_off = 1'b1;
			for (int n = 0; n < 238; n++) begin
				if ($urandom_range(0, 9) == 0) send_load($urandom(), cap);
				else if ($urandom_range(0, 9) < 8)
					send_query(sb.stamps[$urandom_range(0, 3)] + $urandom_range(0, 4000000), cap);
				else send_query($urandom(), cap);
			end
			write_mode((ph % 2) == 1);
		end
		feed_done = 1'b1;
	end

	initial begin
		wait (feed_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
